@@ rtl/laqe_pkg.sv @@
`default_nettype none
package laqe_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	typedef enum logic [2:0] {
		MODE_ENQ    = 3'd0,
		MODE_DEQ    = 3'd1,
		MODE_FRONT  = 3'd2,
		MODE_REAR   = 3'd3,
		MODE_SEARCH = 3'd4,
		MODE_SORT   = 3'd5,
		MODE_STATUS = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [WORD_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [WORD_W-1:0] data;
		logic [CNT_W-1:0]  position;
		logic [CNT_W-1:0]  count;
		logic              is_empty;
		logic              is_full;
	} res_t;

endpackage
`default_nettype wire

@@ rtl/laqe_ram.sv @@
`default_nettype none
module laqe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/laqe_ctrl.sv @@
`default_nettype none
module laqe_ctrl
	import laqe_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [2:0]        mode,
	input  wire logic [WORD_W-1:0] value,
	input  wire logic [WORD_W-1:0] rdata,
	output logic                   idle,
	output logic                   done,
	output mem_req_t               mem,
	output res_t                   res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SRCH,
		S_SORT_I,
		S_SORT_J,
		S_SORT_W
	} state_t;

	state_t            state_q, state_n;
	logic [2:0]        op_q;
	logic [WORD_W-1:0] key_q;
	logic [WORD_W-1:0] cur_q, cur_n;
	logic [IDX_W-1:0]  head_q, head_n, tail_q, tail_n;
	logic [IDX_W-1:0]  idx_q, idx_n, j_q, j_n;
	logic              void_q, void_n;
	logic              full;

	assign full = !void_q && (tail_q == IDX_W'(DEPTH - 1));
	assign idle = (state_q == S_IDLE);

	always_comb begin
		state_n       = state_q;
		head_n        = head_q;
		tail_n        = tail_q;
		void_n        = void_q;
		idx_n         = idx_q;
		j_n           = j_q;
		cur_n         = cur_q;
		done          = 1'b0;
		mem.we        = 1'b0;
		mem.waddr     = tail_q;
		mem.wdata     = value;
		mem.raddr     = head_q;
		res.status    = ST_OK;
		res.data      = '0;
		res.position  = '0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					case (mode)
						MODE_ENQ: begin
							done = 1'b1;
							if (full) begin
								res.status = ST_OVERFLOW;
							end else if (void_q) begin
								head_n    = '0;
								tail_n    = '0;
								void_n    = 1'b0;
								mem.we    = 1'b1;
								mem.waddr = '0;
							end else begin
								tail_n    = tail_q + IDX_W'(1);
								mem.we    = 1'b1;
								mem.waddr = tail_q + IDX_W'(1);
							end
						end
						MODE_DEQ, MODE_FRONT, MODE_REAR: begin
							if (void_q) begin
								res.status = ST_EMPTY;
								done       = 1'b1;
							end else begin
								mem.raddr = (mode == MODE_REAR) ? tail_q : head_q;
								state_n   = S_READ;
							end
						end
						MODE_SEARCH: begin
							if (void_q) begin
								res.status = ST_NOTFOUND;
								done       = 1'b1;
							end else begin
								idx_n   = head_q;
								state_n = S_SRCH;
							end
						end
						MODE_SORT: begin
							// a single word is already in order
							if (void_q || head_q == tail_q) begin
								done = 1'b1;
							end else begin
								idx_n   = head_q;
								state_n = S_SORT_I;
							end
						end
						default: begin
							done = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				res.data = rdata;
				done     = 1'b1;
				state_n  = S_IDLE;
				if (op_q == MODE_DEQ) begin
					if (head_q >= tail_q) begin
						head_n = '0;
						tail_n = '0;
						void_n = 1'b1;
					end else begin
						head_n = head_q + IDX_W'(1);
					end
				end
			end
			S_SRCH: begin
				if (rdata == key_q) begin
					res.position = CNT_W'(idx_q) - CNT_W'(head_q) + CNT_W'(1);
					done         = 1'b1;
					state_n      = S_IDLE;
				end else if (idx_q == tail_q) begin
					res.status = ST_NOTFOUND;
					done       = 1'b1;
					state_n    = S_IDLE;
				end else begin
					mem.raddr = idx_q + IDX_W'(1);
					idx_n     = idx_q + IDX_W'(1);
				end
			end
			S_SORT_I: begin
				cur_n     = rdata;
				mem.raddr = idx_q + IDX_W'(1);
				j_n       = idx_q + IDX_W'(1);
				state_n   = S_SORT_J;
			end
			S_SORT_J: begin
				// carry the smaller word, drop the larger into slot j
				if ($signed(cur_q) > $signed(rdata)) begin
					mem.we    = 1'b1;
					mem.waddr = j_q;
					mem.wdata = cur_q;
					cur_n     = rdata;
				end
				if (j_q == tail_q) begin
					state_n = S_SORT_W;
				end else begin
					mem.raddr = j_q + IDX_W'(1);
					j_n       = j_q + IDX_W'(1);
				end
			end
			S_SORT_W: begin
				mem.we    = 1'b1;
				mem.waddr = idx_q;
				mem.wdata = cur_q;
				if (idx_q + IDX_W'(1) == tail_q) begin
					done    = 1'b1;
					state_n = S_IDLE;
				end else begin
					idx_n     = idx_q + IDX_W'(1);
					mem.raddr = idx_q + IDX_W'(1);
					state_n   = S_SORT_I;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase

		res.count    = void_n ? '0 : (CNT_W'(tail_n) - CNT_W'(head_n) + CNT_W'(1));
		res.is_empty = void_n;
		res.is_full  = !void_n && (tail_n == IDX_W'(DEPTH - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			void_q  <= 1'b1;
		end else begin
			state_q <= state_n;
			head_q  <= head_n;
			tail_q  <= tail_n;
			void_q  <= void_n;
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			op_q  <= mode;
			key_q <= value;
		end
		idx_q <= idx_n;
		j_q   <= j_n;
		cur_q <= cur_n;
	end

endmodule
`default_nettype wire

@@ rtl/linear_array_queue_engine.sv @@
`default_nettype none
// Non-circular array queue of signed 32-bit words with search and sort.
// Input channel (in_valid/in_ready) carries mode and value; output channel
// (out_valid/out_ready) returns one result item per input item: status,
// data, position, count, is_empty and is_full, all taken after the operation.
// One item is worked on at a time; the word store is a single RAM with one
// write and one registered read port, and that port shapes each operation:
//   enqueue, status, and any operation on an empty queue: done as accepted
//   dequeue, front, rear: one RAM read
//   search: words compared in turn from the head up to the first match
//   sort: for each slot, a scan of the later words, then a write back
// Results wait in an output register; the next item is taken in the same
// cycle as the previous result drains, so a stalled receiver holds the block
// with the result steady on the output ports.
// Reset clears the indices and marks the queue empty; the word store itself
// is not cleared, since only written slots are ever read.
module linear_array_queue_engine
	import laqe_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [2:0]               mode,
	input  wire logic signed [WORD_W-1:0] value,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [1:0]                    status,
	output logic signed [WORD_W-1:0]      data,
	output logic [CNT_W-1:0]              position,
	output logic [CNT_W-1:0]              count,
	output logic                          is_empty,
	output logic                          is_full
);

	logic              start, idle, done;
	logic [WORD_W-1:0] rdata;
	mem_req_t          mem;
	res_t              res, res_q;
	logic              res_valid_q;

	assign in_ready = idle && (!res_valid_q || out_ready);
	assign start    = in_valid && in_ready;

	laqe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.value  (value),
		.rdata  (rdata),
		.idle   (idle),
		.done   (done),
		.mem    (mem),
		.res    (res)
	);

	laqe_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem.we),
		.waddr (mem.waddr),
		.wdata (mem.wdata),
		.raddr (mem.raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign out_valid = res_valid_q;
	assign status    = res_q.status;
	assign data      = res_q.data;
	assign position  = res_q.position;
	assign count     = res_q.count;
	assign is_empty  = res_q.is_empty;
	assign is_full   = res_q.is_full;

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (count == '0)))
		else $error("empty flag disagrees with count");

	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OVERFLOW |-> is_full && !is_empty)
		else $error("overflow reported on a queue that is not full");

	a_position_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && position != '0 |-> status == ST_OK && position <= count)
		else $error("search position outside the held words");

	a_done_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !res_valid_q || out_ready)
		else $error("result produced while output register still full");

endmodule
`default_nettype wire
